@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

@@ rtl/core/lz77d_pkg.sv @@
// shared types and field widths of the lz77 triple decoder
package lz77d_pkg;

    localparam int OFF_W  = 12;   // copy_offset field
    localparam int LEN_W  = 5;    // copy_length field
    localparam int BYTE_W = 8;    // literal and output byte
    localparam int CNT_W  = 32;   // byte counter and total_length
    localparam int SAT_W  = 6;    // length compare width, holds MAX_LENGTH up to 63

    typedef logic [BYTE_W-1:0] octet_t;
    typedef logic [CNT_W-1:0]  count_t;

endpackage

@@ rtl/core/lz77d_history.sv @@
// history ring memory with clearing sweep and write-to-read forwarding
`include "assert_macros.svh"

module lz77d_history
    import lz77d_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  octet_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output octet_t        rd_data,
    output logic          clear_busy
);

    octet_t        mem [DEPTH];
    octet_t        rd_q_reg;
    octet_t        fwd_data_reg;
    logic          hit_reg;
    logic          clear_busy_reg;
    logic [AW-1:0] clr_ptr_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    octet_t        mem_wdata;

    // sweep owns the write port until the whole ring is zero
    always_comb begin
        mem_we    = wr_en;
        mem_addr  = wr_addr;
        mem_wdata = wr_data;
        if (clear_busy_reg) begin
            mem_we    = 1'b1;
            mem_addr  = clr_ptr_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_q_reg     <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_ptr_reg    <= '0;
            hit_reg        <= 1'b0;
        end else begin
            // read returns old data on a same-cycle write, so remember the hit
            hit_reg <= wr_en && !clear_busy_reg && (wr_addr == rd_addr);
            if (clear_busy_reg) begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == AW'(DEPTH - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rd_data    = hit_reg ? fwd_data_reg : rd_q_reg;
    assign clear_busy = clear_busy_reg;

    `ASSERT_IMP(a_no_write_in_sweep, aclk, aresetn, clear_busy_reg, !wr_en)
    `ASSERT_NXT(a_fwd_same_addr, aclk, aresetn,
        wr_en && !clear_busy_reg && (wr_addr == rd_addr), rd_data == $past(wr_data))
    `ASSERT_NXT(a_sweep_ends, aclk, aresetn,
        clear_busy_reg && (clr_ptr_reg == AW'(DEPTH - 1)), !clear_busy_reg)

endmodule

@@ rtl/core/lz77_triple_decoder_top.sv @@
// top level of the lz77 triple decoder: triple sequencer, counters and output register
//
//  channel   direction  ports                                          transaction
//  s_*       in         s_copy_offset, s_copy_length, s_literal_byte   one (offset,length,literal)
//  m_*       out        m_out_byte, m_last_of_triple, m_end_of_data    one decoded byte
//  cfg_*     in         cfg_we, cfg_wdata                              total_length write
//
//  a triple is accepted in IDLE, which starts the history read; then its bytes leave one
//  per cycle, while m_ready allows, out of the single read port of the history ring;
//  a triple past the size limit is accepted and dropped
//  after reset the ring is swept to zero, one entry per cycle, with s_ready low;
//  cfg writes are taken during the sweep
//  a stall on m_ready holds the sequencer; the source read is repeated until the byte goes
`include "assert_macros.svh"

module lz77_triple_decoder_top
    import lz77d_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4096,
    parameter int MAX_LENGTH   = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    // triple input
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OFF_W-1:0] s_copy_offset,
    input  logic [LEN_W-1:0] s_copy_length,
    input  logic [BYTE_W-1:0] s_literal_byte,
    // byte output
    output logic             m_valid,
    input  logic             m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic             m_last_of_triple,
    output logic             m_end_of_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    // restoring reduction steps for offset modulo window
    localparam int RED_STEPS = (WINDOW_DEPTH >= (1 << OFF_W)) ? 1 : (OFF_W - AW + 1);
    // signed-safe width for the pointer difference
    localparam int DW = ((AW > OFF_W) ? AW : OFF_W) + 2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // control state
    state_t        state_reg;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] src_reg;
    logic [LW-1:0] copy_cnt_reg;
    count_t        emitted_reg;
    count_t        total_reg;
    logic          m_valid_reg;
    // payload
    octet_t        lit_reg;
    octet_t        m_byte_reg;
    logic          m_last_reg;
    logic          m_end_reg;

    logic          clear_busy;
    octet_t        hist_rd_data;
    logic [AW-1:0] src_next;

    logic          accept;
    logic          out_free;
    logic          emit;
    logic          is_copy;
    logic          at_end;
    logic          byte_last;
    octet_t        byte_val;
    count_t        cnt_inc;

    logic [OFF_W:0] off_red;
    logic [DW-1:0]  diff;
    logic [AW-1:0]  src_start;
    logic [SAT_W-1:0] len_ext;
    logic [SAT_W-1:0] len_sat;

    assign s_ready = (state_reg == ST_IDLE) && !clear_busy;
    assign accept  = s_valid && s_ready;

    // offset modulo window, then source = write pointer minus offset around the ring
    always_comb begin
        off_red = (OFF_W + 1)'(s_copy_offset);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (off_red >= (OFF_W + 1)'(WINDOW_DEPTH << k)) begin
                off_red = off_red - (OFF_W + 1)'(WINDOW_DEPTH << k);
            end
        end
        diff = DW'(wp_reg) - DW'(off_red);
        if (diff[DW-1]) begin
            diff = diff + DW'(WINDOW_DEPTH);
        end
        src_start = diff[AW-1:0];
    end

    // copy length saturates at MAX_LENGTH
    always_comb begin
        len_ext = SAT_W'(s_copy_length);
        len_sat = (len_ext > SAT_W'(MAX_LENGTH)) ? SAT_W'(MAX_LENGTH) : len_ext;
    end

    // one byte leaves per cycle in RUN whenever the output register can take it
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (state_reg == ST_RUN) && out_free;
    assign is_copy   = (copy_cnt_reg != '0);
    assign byte_val  = is_copy ? hist_rd_data : lit_reg;
    assign cnt_inc   = emitted_reg + 1'b1;
    assign at_end    = (cnt_inc == total_reg);
    // literal closes the triple, reaching total_length cuts it short
    assign byte_last = !is_copy || at_end;

    // read address is the next source pointer, so the registered read data lines up with the next byte
    always_comb begin
        src_next = src_reg;
        if (accept) begin
            src_next = src_start;
        end else if (emit && is_copy) begin
            src_next = ptr_inc(src_reg);
        end
    end

    lz77d_history #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_history (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (emit),
        .wr_addr    (wp_reg),
        .wr_data    (byte_val),
        .rd_addr    (src_next),
        .rd_data    (hist_rd_data),
        .clear_busy (clear_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            src_reg      <= '0;
            copy_cnt_reg <= '0;
            emitted_reg  <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            src_reg <= src_next;
            if (cfg_we) begin
                total_reg <= cfg_wdata;
            end
            if (accept) begin
                lit_reg <= s_literal_byte;
            end

            // output register loads on a new byte, empties when the receiver takes it
            if (emit) begin
                m_valid_reg <= 1'b1;
                m_byte_reg  <= byte_val;
                m_last_reg  <= byte_last;
                m_end_reg   <= at_end;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // a triple past the size limit is taken and dropped
                    if (accept && (emitted_reg < total_reg)) begin
                        state_reg    <= ST_RUN;
                        copy_cnt_reg <= len_sat[LW-1:0];
                    end
                end
                ST_RUN: begin
                    if (emit) begin
                        wp_reg      <= ptr_inc(wp_reg);
                        emitted_reg <= cnt_inc;
                        if (is_copy) begin
                            copy_cnt_reg <= copy_cnt_reg - 1'b1;
                        end
                        if (byte_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = m_byte_reg;
    assign m_last_of_triple = m_last_reg;
    assign m_end_of_data    = m_end_reg;

    `ASSERT_IMP(a_end_is_last, aclk, aresetn, m_valid && m_end_of_data, m_last_of_triple)
    `ASSERT_NXT(a_literal_closes, aclk, aresetn, emit && !is_copy, state_reg == ST_IDLE)
    `ASSERT_IMP(a_run_after_sweep, aclk, aresetn, state_reg == ST_RUN, !clear_busy)

endmodule
